[hw/rtl/kda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int CNT_W      = 8;
    localparam int KEY_CODE_W = $clog2(NUM_KEYS + 1);
    localparam int CFG_DATA_W = (NUM_KEYS > CNT_W) ? NUM_KEYS : CNT_W;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_EN    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]    RST_DEBOUNCE   = 8'd5;
    localparam logic [CNT_W-1:0]    RST_REPEAT     = 8'd20;
    localparam logic [CNT_W-1:0]    RST_HOLD_DELAY = 8'd100;
    localparam logic [NUM_KEYS-1:0] RST_HOLD_EN    = '0;

    // Hold counter marker values.
    localparam logic [CNT_W-1:0] MARK_NO_HOLD = 8'hFF;
    localparam logic [CNT_W-1:0] MARK_HOLD    = 8'hFE;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] repeat_ticks;
        logic [CNT_W-1:0] hold_delay_ticks;
    } t_key_cfg;

    typedef struct packed {
        logic             was_pressed;
        logic             debounced;
        logic [CNT_W-1:0] debounce_count;
        logic [CNT_W-1:0] hold_count;
        logic             repeat_active;
    } t_key_state;

    typedef struct packed {
        logic [NUM_KEYS-1:0]   pulse_mask;
        logic [KEY_CODE_W-1:0] key_code;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/kda_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module kda_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_pressed,
    input  wire logic              i_hold_en,
    input  wire kda_pkg::t_key_cfg i_cfg,
    output logic                   o_debounced
);

    kda_pkg::t_key_state r_st;
    kda_pkg::t_key_state n_st;

    always_comb begin
        logic [kda_pkg::CNT_W-1:0] dc_inc;
        logic [kda_pkg::CNT_W-1:0] hc;
        logic                      ra;

        n_st   = r_st;
        dc_inc = r_st.debounce_count + kda_pkg::CNT_W'(1);
        hc     = r_st.hold_count;
        ra     = r_st.repeat_active;
        if (!i_pressed) begin
            n_st = '0;
        end else if (!r_st.was_pressed) begin
            n_st.hold_count     = '0;
            n_st.debounce_count = '0;
            n_st.debounced      = (i_cfg.debounce_ticks == kda_pkg::CNT_W'(1));
            n_st.was_pressed    = 1'b1;
            n_st.repeat_active  = 1'b0;
        end else if (!r_st.debounced && (r_st.hold_count == '0)) begin
            n_st.debounce_count = dc_inc;
            if (dc_inc >= i_cfg.debounce_ticks) begin
                n_st.debounce_count = i_cfg.debounce_ticks;
                n_st.debounced      = 1'b1;
                n_st.hold_count     = i_hold_en ? kda_pkg::MARK_HOLD
                                                : kda_pkg::MARK_NO_HOLD;
            end
        end else if (!r_st.debounced) begin
            // Waiting for the hold delay, then counting repeat periods.
            if (i_hold_en && (hc == kda_pkg::MARK_NO_HOLD)) begin
                hc = kda_pkg::CNT_W'(1);
            end else if (i_hold_en && !ra) begin
                hc = hc + kda_pkg::CNT_W'(1);
                if (hc >= i_cfg.hold_delay_ticks) begin
                    ra = 1'b1;
                end
            end
            if (ra && i_hold_en && (hc != '0)) begin
                hc = hc + kda_pkg::CNT_W'(1);
                if (hc >= i_cfg.repeat_ticks) begin
                    hc             = '0;
                    n_st.debounced = 1'b1;
                end
            end
            n_st.hold_count    = hc;
            n_st.repeat_active = ra;
        end else begin
            // A pulse lasts one tick.
            n_st.debounced = 1'b0;
            if (i_hold_en) begin
                n_st.hold_count = r_st.hold_count + kda_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_load) begin
            r_st <= n_st;
        end
    end

    assign o_debounced = n_st.debounced;

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && !i_pressed) |=> (r_st == '0))
        else $error("released key left state behind");

    a_pulse_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.debounced |-> r_st.was_pressed)
        else $error("pulse on a key that is not pressed");

    a_repeat_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.repeat_active |-> r_st.was_pressed)
        else $error("repeat active on a key that is not pressed");

endmodule

`default_nettype wire

[hw/rtl/kda_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module kda_merge (
    input  wire logic [kda_pkg::NUM_KEYS-1:0] i_debounced,
    output kda_pkg::t_result                  o_result
);

    always_comb begin
        o_result.pulse_mask = i_debounced;
        o_result.key_code   = kda_pkg::KEY_CODE_W'(kda_pkg::NUM_KEYS);
        // Scan from the top so the lowest-numbered key wins.
        for (int k = kda_pkg::NUM_KEYS - 1; k >= 0; k--) begin
            if (i_debounced[k]) begin
                o_result.key_code = kda_pkg::KEY_CODE_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/key_debounce_autorepeat.sv]
// Debounce and press-and-hold auto-repeat for a small bank of keys.
//
// Input channel (i_valid / o_ready, i_buttons): one word per periodic tick
// carrying the raw level of every key. Output channel (o_valid / i_ready,
// o_pulse_mask, o_key_code): exactly one word per input word, giving the
// debounced state of each key after that tick and the lowest-numbered key
// whose bit is set (NUM_KEYS when none is).
//
// Every key has its own lane holding its debounce and hold counters; all
// lanes update in the cycle a word is accepted and a priority encoder
// merges their bits. The result is registered, and one word is taken every
// cycle while o_ready is high.
//
// A two-entry output stage (result register plus skid register) lets the
// block take a word while an earlier result still waits; o_ready drops only
// when both entries are full, so a stalled receiver holds back the sender
// after two words. Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data)
// take effect at once and are meant to be done while the block is idle.
// Synchronous reset clears all key state, empties the output stage and
// loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_autorepeat (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [kda_pkg::NUM_KEYS-1:0]       i_buttons,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [kda_pkg::NUM_KEYS-1:0]            o_pulse_mask,
    output logic [kda_pkg::KEY_CODE_W-1:0]          o_key_code,
    input  wire logic                               i_cfg_we,
    input  wire logic [kda_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [kda_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    kda_pkg::t_key_cfg                r_cfg;
    logic [kda_pkg::NUM_KEYS-1:0]     r_hold_en;
    logic [kda_pkg::NUM_KEYS-1:0]     lane_db;
    kda_pkg::t_result                 merged;
    kda_pkg::t_result                 r_out;
    kda_pkg::t_result                 r_skid;
    logic                             r_out_valid;
    logic                             r_skid_valid;
    logic                             accept;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= kda_pkg::RST_DEBOUNCE;
            r_cfg.repeat_ticks     <= kda_pkg::RST_REPEAT;
            r_cfg.hold_delay_ticks <= kda_pkg::RST_HOLD_DELAY;
            r_hold_en              <= kda_pkg::RST_HOLD_EN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kda_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce_ticks <= i_cfg_data[kda_pkg::CNT_W-1:0];
                end
                kda_pkg::REG_REPEAT: begin
                    r_cfg.repeat_ticks <= i_cfg_data[kda_pkg::CNT_W-1:0];
                end
                kda_pkg::REG_HOLD_DELAY: begin
                    r_cfg.hold_delay_ticks <= i_cfg_data[kda_pkg::CNT_W-1:0];
                end
                kda_pkg::REG_HOLD_EN: begin
                    r_hold_en <= i_cfg_data[kda_pkg::NUM_KEYS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < kda_pkg::NUM_KEYS; k++) begin : g_lane
        kda_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (accept),
            .i_pressed   (i_buttons[k]),
            .i_hold_en   (r_hold_en[k]),
            .i_cfg       (r_cfg),
            .o_debounced (lane_db[k])
        );
    end

    kda_merge u_merge (
        .i_debounced (lane_db),
        .o_result    (merged)
    );

    // Result register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || i_ready) begin
                r_out <= merged;
            end else begin
                r_skid <= merged;
            end
        end else if (i_ready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pulse_mask = r_out.pulse_mask;
    assign o_key_code   = r_out.key_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while result register empty");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word produced no result");

    a_stall_keeps_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("buffered word lost during stall");

endmodule

`default_nettype wire
